// ----- rtl/tga_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tga_pkg;

    localparam int MAP_DEPTH = 256;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int IDX_W     = 16;

    // colormap depth as a compare limit, one bit wider than any index
    localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W + 1)'(MAP_DEPTH);

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;
    localparam int CFG_W    = 6;

    typedef enum logic [1:0] {
        CFG_PIXEL_BITS = 2'd0,
        CFG_RLE_ON     = 2'd1,
        CFG_MAP_ON     = 2'd2,
        CFG_OUT_MODE   = 2'd3
    } cfg_idx_t;

    localparam logic [1:0] OUT_GRAY = 2'd0;
    localparam logic [1:0] OUT_RGB  = 2'd1;
    localparam logic [1:0] OUT_ARGB = 2'd2;

    localparam logic ACT_STREAM    = 1'b0;
    localparam logic ACT_MAP_WRITE = 1'b1;

    localparam logic [5:0] PIXEL_BITS_RST = 6'd24;

    typedef struct packed {
        logic [5:0] pixel_bits;
        logic       rle_on;
        logic       map_on;
        logic [1:0] out_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_cnt;
        logic       mapped;
        logic       in_range;
        logic [1:0] out_mode;
    } pix_t;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [MAP_AW-1:0] raddr;
    } map_port_t;

    function automatic logic [2:0] bytes_per_pixel(input logic [5:0] pixel_bits);
        logic [2:0] nb;
        if (pixel_bits == 6'd8) begin
            nb = 3'd1;
        end else if (pixel_bits == 6'd15 || pixel_bits == 6'd16) begin
            nb = 3'd2;
        end else if (pixel_bits == 6'd32) begin
            nb = 3'd4;
        end else begin
            nb = 3'd3;
        end
        return nb;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tga_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/tga_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tga_parse
    import tga_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_t                cfg,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    input  wire logic                s_axis_tuser,
    input  wire logic                out_free,
    output logic                     s1_valid,
    output pix_t                     s1_pix,
    output map_port_t                map_port
);

    logic        await_header_reg, await_header_next;
    logic        run_rep_reg, run_rep_next;
    logic [7:0]  run_left_reg, run_left_next;
    logic [1:0]  phase_reg, phase_next;
    logic [23:0] hold_reg, hold_next;
    logic        s1_valid_reg, s1_valid_next;
    pix_t        s1_pix_reg, s1_pix_next;

    logic             accept;
    logic             done;
    logic [7:0]       b;
    logic [7:0]       lo;
    logic [2:0]       nb;
    logic [IDX_W-1:0] idx;
    logic [7:0]       r, g, bl, a;
    logic [7:0]       rep;
    logic [7:0]       left_dec;

    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata[7:0];
    assign lo            = hold_reg[7:0];
    assign nb            = bytes_per_pixel(cfg.pixel_bits);
    assign left_dec      = (run_left_reg != 8'd0) ? run_left_reg - 8'd1 : 8'd0;

    // channel assembly for the byte that closes a pixel
    always_comb begin
        r   = 8'd0;
        g   = 8'd0;
        bl  = 8'd0;
        a   = 8'd0;
        idx = '0;
        unique case (nb)
            3'd1: begin
                r   = b;
                g   = b;
                bl  = b;
                idx = IDX_W'(b);
            end
            3'd2: begin
                r   = {3'b000, b[6:2]};
                g   = {3'b000, b[1:0], lo[7:5]};
                bl  = {3'b000, lo[4:0]};
                idx = {b, lo};
            end
            3'd3: begin
                bl = hold_reg[15:8];
                g  = hold_reg[7:0];
                r  = b;
            end
            default: begin
                bl = hold_reg[23:16];
                g  = hold_reg[15:8];
                r  = hold_reg[7:0];
                a  = b;
            end
        endcase
    end

    always_comb begin
        await_header_next = await_header_reg;
        run_rep_next      = run_rep_reg;
        run_left_next     = run_left_reg;
        phase_next        = phase_reg;
        hold_next         = hold_reg;
        done              = 1'b0;
        rep               = 8'd1;
        map_port.we       = 1'b0;
        map_port.waddr    = MAP_AW'(s_axis_tdata[15:8]);
        map_port.wdata    = {s_axis_tdata[47:40], s_axis_tdata[23:16],
                             s_axis_tdata[31:24], s_axis_tdata[39:32]};
        map_port.raddr    = MAP_AW'(idx);

        if (accept) begin
            priority if (s_axis_tuser == ACT_MAP_WRITE) begin
                map_port.we = (17'(s_axis_tdata[15:8]) < DEPTH_LIM);
            end else if (cfg.rle_on && await_header_reg) begin
                run_rep_next      = b[7];
                run_left_next     = {1'b0, b[6:0]} + 8'd1;
                await_header_next = 1'b0;
                phase_next        = 2'd0;
                hold_next         = 24'd0;
            end else if (({1'b0, phase_reg} + 3'd1) < nb) begin
                hold_next  = {hold_reg[15:0], b};
                phase_next = phase_reg + 2'd1;
            end else begin
                done       = 1'b1;
                phase_next = 2'd0;
                hold_next  = 24'd0;
                if (cfg.rle_on) begin
                    if (run_rep_reg) begin
                        rep               = (run_left_reg == 8'd0) ? 8'd1 : run_left_reg;
                        run_left_next     = 8'd0;
                        await_header_next = 1'b1;
                    end else begin
                        run_left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            await_header_next = 1'b1;
                        end
                    end
                end
            end
        end
        map_port.re = done;
    end

    always_comb begin
        s1_pix_next            = s1_pix_reg;
        s1_pix_next.red        = r;
        s1_pix_next.green      = g;
        s1_pix_next.blue       = bl;
        s1_pix_next.alpha      = a;
        s1_pix_next.repeat_cnt = rep;
        s1_pix_next.mapped     = cfg.map_on;
        s1_pix_next.in_range   = ({1'b0, idx} < DEPTH_LIM);
        s1_pix_next.out_mode   = cfg.out_mode;

        // an item leaving toward the output empties the stage unless a new pixel lands
        if (accept) begin
            s1_valid_next = done;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            await_header_reg <= 1'b1;
            run_rep_reg      <= 1'b0;
            run_left_reg     <= 8'd0;
            phase_reg        <= 2'd0;
            hold_reg         <= 24'd0;
            s1_valid_reg     <= 1'b0;
        end else begin
            await_header_reg <= await_header_next;
            run_rep_reg      <= run_rep_next;
            run_left_reg     <= run_left_next;
            phase_reg        <= phase_next;
            hold_reg         <= hold_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && done) begin
            s1_pix_reg <= s1_pix_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_pix   = s1_pix_reg;

endmodule

`default_nettype wire

// ----- rtl/tga_fmt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tga_fmt
    import tga_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s1_valid,
    input  wire pix_t                s1_pix,
    input  wire logic [31:0]         ram_rdata,
    input  wire logic                m_axis_tready,
    output logic                     m_axis_tvalid,
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    output logic                     m_axis_tuser,
    output logic                     out_free
);

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_err_reg;

    logic [7:0] r, g, bl, a;
    logic       err;

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        r   = s1_pix.red;
        g   = s1_pix.green;
        bl  = s1_pix.blue;
        a   = s1_pix.alpha;
        err = 1'b0;
        if (s1_pix.mapped) begin
            if (s1_pix.in_range) begin
                a  = ram_rdata[31:24];
                r  = ram_rdata[23:16];
                g  = ram_rdata[15:8];
                bl = ram_rdata[7:0];
            end else begin
                err = 1'b1;
                r   = 8'd0;
                g   = 8'd0;
                bl  = 8'd0;
                a   = 8'd0;
            end
        end
        // gray keeps red only, the unused mode code behaves as rgb
        if (s1_pix.out_mode == OUT_GRAY) begin
            g  = 8'd0;
            bl = 8'd0;
            a  = 8'd0;
        end else if (s1_pix.out_mode != OUT_ARGB) begin
            a = 8'd0;
        end
        m_valid_next = out_free ? s1_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid) begin
            m_data_reg <= {s1_pix.repeat_cnt, a, bl, g, r};
            m_err_reg  <= err;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_err_reg;

endmodule

`default_nettype wire

// ----- rtl/tga_rle_pixel_decoder.sv -----
// the pixel completed by an item is registered in the parse stage, then in the output register behind m_axis_tvalid
// throughput: one item per cycle while the output is not stalled; the colormap has a single read port
// header bytes, partial pixel bytes and colormap writes give no result
// reset: synchronous, active low; clears parser state, pipeline valids and the
// configuration registers to their defaults; colormap contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder
    import tga_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_addr,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // data_byte[7:0], map_index[15:8], map_red[23:16], map_green[31:24],
    // map_blue[39:32], map_alpha[47:40]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // action[0]
    input  wire logic                s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24], repeat_res[39:32]
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    // index_error[0]
    output logic                     m_axis_tuser
);

    cfg_t      cfg_reg, cfg_next;
    logic      out_free;
    logic      s1_valid;
    pix_t      s1_pix;
    map_port_t map_port;
    logic [31:0] ram_rdata;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_PIXEL_BITS: cfg_next.pixel_bits = cfg_wdata;
                CFG_RLE_ON:     cfg_next.rle_on     = cfg_wdata[0];
                CFG_MAP_ON:     cfg_next.map_on     = cfg_wdata[0];
                CFG_OUT_MODE:   cfg_next.out_mode   = cfg_wdata[1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_bits <= PIXEL_BITS_RST;
            cfg_reg.rle_on     <= 1'b0;
            cfg_reg.map_on     <= 1'b0;
            cfg_reg.out_mode   <= OUT_RGB;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tga_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .out_free      (out_free),
        .s1_valid      (s1_valid),
        .s1_pix        (s1_pix),
        .map_port      (map_port)
    );

    tga_ram #(
        .WIDTH (32),
        .DEPTH (MAP_DEPTH)
    ) u_color_map (
        .aclk  (aclk),
        .we    (map_port.we),
        .waddr (map_port.waddr),
        .wdata (map_port.wdata),
        .re    (map_port.re),
        .raddr (map_port.raddr),
        .rdata (ram_rdata)
    );

    tga_fmt u_fmt (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s1_valid      (s1_valid),
        .s1_pix        (s1_pix),
        .ram_rdata     (ram_rdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .out_free      (out_free)
    );

endmodule

`default_nettype wire

// ----- rtl/tga_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tga_checker
    import tga_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                cfg_we,
    input wire logic [1:0]          cfg_addr,
    input wire logic [CFG_W-1:0]    cfg_wdata,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [S_DATA_W-1:0] s_axis_tdata,
    input wire logic                s_axis_tuser,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata,
    input wire logic                m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // repeat count is never zero
    a_rep_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:32] != 8'd0)
        else $error("repeat count of zero");

    // a bad colormap index gives all channels zero
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
        else $error("index error with nonzero channels");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind tga_rle_pixel_decoder tga_checker u_tga_checker (.*);

`default_nettype wire

// ----- tb/tb_tga_rle_pixel_decoder.sv -----
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;
    import tga_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int STREAM_ITEMS = 1850;

    typedef struct packed {
        logic       action;
        logic [7:0] map_alpha;
        logic [7:0] map_blue;
        logic [7:0] map_green;
        logic [7:0] map_red;
        logic [7:0] map_index;
        logic [7:0] data_byte;
    } tga_item_t;

    // laid out as {m_axis_tdata, m_axis_tuser}
    typedef struct packed {
        logic [7:0] repeat_res;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       index_error;
    } pixel_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_addr = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    tga_rle_pixel_decoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 aclk = ~aclk;

    // decoder copy: configuration, parser state and colormap
    logic [5:0]  pix_bits = PIXEL_BITS_RST;
    logic        rle_en = 1'b0;
    logic        map_en = 1'b0;
    logic [1:0]  fmt = OUT_RGB;
    logic        hdr_wait = 1'b1;
    logic        run_rep = 1'b0;
    logic [7:0]  run_cnt = '0;
    logic [1:0]  byte_cnt = '0;
    logic [23:0] byte_acc = '0;
    logic [31:0] palette [0:MAP_DEPTH-1];

    tga_item_t pending_bytes[$];
    pixel_t    expected_pixels[$];
    tga_item_t cur_item;

    int  err_cnt = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_settings = 0;
    int  n_queued = 0;
    int  quiet_cycles = 0;
    int  src_wait = 0;
    int  sink_wait = 0;
    bit  src_busy = 0;
    bit  src_mode = 0;
    bit  sink_mode = 0;
    pixel_t got_px;
    pixel_t want_px;

    function automatic int unsigned pixel_bytes(input logic [5:0] bits);
        int unsigned nb;
        case (bits)
            6'd8:         nb = 1;
            6'd15, 6'd16: nb = 2;
            6'd32:        nb = 4;
            default:      nb = 3;
        endcase
        return nb;
    endfunction

    // advance the decoder copy by one item, queue the pixel it completes
    task automatic predict_pixel(input tga_item_t it);
        int unsigned nb;
        logic [7:0]  b;
        logic [7:0]  lo;
        logic [15:0] idx;
        logic [31:0] entry;
        pixel_t      px;
        b = it.data_byte;
        nb = pixel_bytes(pix_bits);
        px = '0;
        idx = '0;
        if (it.action == ACT_MAP_WRITE) begin
            if (32'(it.map_index) < MAP_DEPTH) begin
                palette[it.map_index] = {it.map_alpha, it.map_red, it.map_green, it.map_blue};
            end
        end else if (rle_en && hdr_wait) begin
            run_rep = b[7];
            run_cnt = {1'b0, b[6:0]} + 8'd1;
            hdr_wait = 1'b0;
            byte_cnt = '0;
            byte_acc = '0;
        end else if (int'(byte_cnt) + 1 < nb) begin
            byte_acc = {byte_acc[15:0], b};
            byte_cnt = byte_cnt + 2'd1;
        end else begin
            if (nb == 1) begin
                px.red = b;
                px.green = b;
                px.blue = b;
                idx = {8'h00, b};
            end else if (nb == 2) begin
                lo = byte_acc[7:0];
                px.red = {3'b000, b[6:2]};
                px.green = {3'b000, b[1:0], lo[7:5]};
                px.blue = {3'b000, lo[4:0]};
                idx = {b, lo};
            end else if (nb == 3) begin
                px.blue = byte_acc[15:8];
                px.green = byte_acc[7:0];
                px.red = b;
            end else begin
                px.blue = byte_acc[23:16];
                px.green = byte_acc[15:8];
                px.red = byte_acc[7:0];
                px.alpha = b;
            end
            byte_cnt = '0;
            byte_acc = '0;
            if (map_en) begin
                if (32'(idx) < MAP_DEPTH) begin
                    entry = palette[idx[MAP_AW-1:0]];
                    {px.alpha, px.red, px.green, px.blue} = entry;
                end else begin
                    px.index_error = 1'b1;
                    px.red = '0;
                    px.green = '0;
                    px.blue = '0;
                    px.alpha = '0;
                end
            end
            if (fmt == OUT_GRAY) begin
                px.green = '0;
                px.blue = '0;
                px.alpha = '0;
            end else if (fmt != OUT_ARGB) begin
                px.alpha = '0;
            end
            px.repeat_res = 8'd1;
            if (rle_en) begin
                if (run_rep) begin
                    px.repeat_res = (run_cnt == 0) ? 8'd1 : run_cnt;
                    run_cnt = '0;
                    hdr_wait = 1'b1;
                end else begin
                    if (run_cnt > 0) run_cnt = run_cnt - 8'd1;
                    if (run_cnt == 0) hdr_wait = 1'b1;
                end
            end
            expected_pixels.push_back(px);
        end
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            src_wait = 0;
            src_busy = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pixel(cur_item);
                n_sent++;
                src_busy = 0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    cur_item = pending_bytes.pop_front();
                    src_busy = 1;
                    s_axis_tdata <= {cur_item.map_alpha, cur_item.map_blue, cur_item.map_green,
                                     cur_item.map_red, cur_item.map_index, cur_item.data_byte};
                    s_axis_tuser <= cur_item.action;
                    s_axis_tvalid <= 1'b1;
                    src_wait = src_mode ? $urandom_range(0, 6) : 0;
                    if ($urandom_range(0, 39) == 0) src_mode = !src_mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_px = {m_axis_tdata, m_axis_tuser};
                n_checked++;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel result %h", got_px);
                    err_cnt++;
                end else begin
                    want_px = expected_pixels.pop_front();
                    if (got_px.red !== want_px.red) begin
                        $error("red: expected %0d, got %0d", want_px.red, got_px.red);
                        err_cnt++;
                    end
                    if (got_px.green !== want_px.green) begin
                        $error("green: expected %0d, got %0d", want_px.green, got_px.green);
                        err_cnt++;
                    end
                    if (got_px.blue !== want_px.blue) begin
                        $error("blue: expected %0d, got %0d", want_px.blue, got_px.blue);
                        err_cnt++;
                    end
                    if (got_px.alpha !== want_px.alpha) begin
                        $error("alpha: expected %0d, got %0d", want_px.alpha, got_px.alpha);
                        err_cnt++;
                    end
                    if (got_px.repeat_res !== want_px.repeat_res) begin
                        $error("repeat_res: expected %0d, got %0d",
                               want_px.repeat_res, got_px.repeat_res);
                        err_cnt++;
                    end
                    if (got_px.index_error !== want_px.index_error) begin
                        $error("index_error: expected %0d, got %0d",
                               want_px.index_error, got_px.index_error);
                        err_cnt++;
                    end
                end
                sink_wait = sink_mode ? $urandom_range(0, 6) : 0;
                if ($urandom_range(0, 29) == 0) sink_mode = !sink_mode;
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        tga_item_t it;
        it = tga_item_t'(49'({$urandom, $urandom}));
        it.action = ACT_STREAM;
        it.data_byte = b;
        pending_bytes.push_back(it);
        n_queued++;
    endtask

    task automatic push_map(input logic [7:0] idx, input logic [31:0] argb);
        tga_item_t it;
        it.action = ACT_MAP_WRITE;
        it.data_byte = 8'($urandom);
        it.map_index = idx;
        {it.map_alpha, it.map_red, it.map_green, it.map_blue} = argb;
        pending_bytes.push_back(it);
        n_queued++;
    endtask

    // one pixel worth of bytes at the current pixel size
    task automatic push_pixel();
        int unsigned nb;
        nb = pixel_bytes(pix_bits);
        for (int k = 0; k < nb; k++) begin
            // in mapped 15- or 16-bit mode keep at least half the indices inside the colormap
            if (map_en && nb == 2 && k == 1 && $urandom_range(0, 1) == 0) begin
                push_byte(8'h00);
            end else begin
                push_byte(rand_byte());
            end
        end
    endtask

    task automatic push_packet();
        logic       rep;
        logic [6:0] cnt;
        int unsigned r;
        rep = $urandom_range(0, 1);
        r = $urandom_range(0, 39);
        if (r == 0) cnt = 7'd127;
        else if (r < 4) cnt = 7'($urandom_range(0, 127));
        else if (r < 6) cnt = 7'd0;
        else cnt = 7'($urandom_range(0, 7));
        push_byte({rep, cnt});
        if (rep) begin
            push_pixel();
        end else begin
            for (int k = 0; k <= cnt; k++) push_pixel();
        end
    endtask

    task automatic set_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PIXEL_BITS: pix_bits = val;
            CFG_RLE_ON:     rle_en = val[0];
            CFG_MAP_ON:     map_en = val[0];
            default:        fmt = val[1:0];
        endcase
    endtask

    // unused upper bits of the narrow registers carry random noise
    task automatic write_cfg(input logic [5:0] bits, input logic rle, input logic map,
                             input logic [1:0] om);
        set_reg(CFG_PIXEL_BITS, bits);
        set_reg(CFG_RLE_ON, {5'($urandom), rle});
        set_reg(CFG_MAP_ON, {5'($urandom), map});
        set_reg(CFG_OUT_MODE, {4'($urandom), om});
        @(posedge aclk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || src_busy || expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int unsigned r;
        int          phase_len;
        int          phase_no;
        logic [5:0]  bits;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // fill the whole colormap so no mapped pixel reads an unwritten entry
        for (int i = 0; i < MAP_DEPTH; i++) push_map(8'(i), $urandom);
        wait_drained();

        // reset configuration, full-scale 24-bit pixels, then a partial one
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'h7F);
        wait_drained();
        // 8-bit gray: the partial 24-bit pixel completes on the next byte
        write_cfg(6'd8, 1'b0, 1'b0, OUT_GRAY);
        push_byte(8'hFF); push_byte(8'h00);
        wait_drained();
        write_cfg(6'd32, 1'b0, 1'b0, OUT_ARGB);
        push_byte(8'h11); push_byte(8'h22); push_byte(8'h33); push_byte(8'hFF);
        wait_drained();
        // mapped 16-bit, out_mode 3: index out of range, then in range
        write_cfg(6'd16, 1'b0, 1'b1, 2'd3);
        push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'h05); push_byte(8'h00);
        wait_drained();
        // 15-bit run-length: replicated run of two, literal run of one
        write_cfg(6'd15, 1'b1, 1'b0, OUT_RGB);
        push_byte(8'h81); push_byte(8'hE0); push_byte(8'h7F);
        push_byte(8'h00); push_byte(8'h1F); push_byte(8'h80);
        wait_drained();
        // illegal size decodes as 24, longest replicated run, mapped entry 0
        write_cfg(6'd0, 1'b1, 1'b1, OUT_ARGB);
        push_map(8'hFF, 32'hFFFF_FFFF);
        push_byte(8'hFF); push_byte(8'h12); push_byte(8'h34); push_byte(8'h56);
        wait_drained();

        phase_no = 0;
        while (n_queued < STREAM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (phase_no == 0) bits = 6'd63;
            else if (r < 7) begin
                case ($urandom_range(0, 4))
                    0: bits = 6'd8;
                    1: bits = 6'd15;
                    2: bits = 6'd16;
                    3: bits = 6'd24;
                    default: bits = 6'd32;
                endcase
            end else if (r == 7) bits = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
            else bits = 6'($urandom_range(0, 63));
            write_cfg(bits, $urandom_range(0, 2) != 0, $urandom_range(0, 1) != 0,
                      2'($urandom_range(0, 3)));
            phase_len = n_queued + $urandom_range(40, 160);
            while (n_queued < phase_len) begin
                r = $urandom_range(0, 99);
                if (r < 6) push_map(8'($urandom), $urandom);
                else if (r < 12) push_byte(rand_byte());
                else if (rle_en) push_packet();
                else push_pixel();
            end
            wait_drained();
            phase_no++;
        end

        repeat (20) @(posedge aclk);
        if (expected_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", expected_pixels.size());
            err_cnt++;
        end
        $display("sent %0d stream bytes and colormap writes under %0d register settings",
                 n_sent, n_settings);
        $display("checked %0d pixel results, %0d mismatches", n_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
